@@ rtl/hgvb_pkg.sv @@
// Shared types, constants and register indexes of the heightmap grid vertex builder.
package hgvb_pkg;

  // Sizing of the grid and the texture map
  localparam int TEXTURE_SLOTS = 8;
  localparam int MAX_ROW       = 256;

  // Configuration port
  localparam int REG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [REG_INDEX_W-1:0] REG_ROW_SIZE      = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_PHYSICAL_SIZE = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_BASIS_X_ROW   = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_BASIS_Y_ROW   = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_BASIS_Z_ROW   = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_OFFSET_XY     = 3'd5;
  localparam logic [REG_INDEX_W-1:0] REG_OFFSET_Z      = 3'd6;
  localparam logic [REG_INDEX_W-1:0] REG_TEXTURE_MAP   = 3'd7;

  // Unmapped texture pool id
  localparam logic [7:0] POOL_UNMAPPED = 8'hFF;

  // Datapath pipeline depth (input register to output register)
  localparam int PIPE_STAGES = 9;

  // Setup divider: 33-bit dividend, one quotient bit per cycle
  localparam int DIV_STEPS = 33;

  // Half an LSB of Q16.16 at Q.34, placed under the shifted offset
  localparam logic [17:0] ROUND_HALF = 18'h20000;

  // Setup sequencer
  typedef enum logic [1:0] {
    SEQ_LOAD,
    SEQ_DIV,
    SEQ_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    JOB_STEP,
    JOB_RECIP_D,
    JOB_RECIP_N
  } job_t;

  // Grid constants derived from row size and physical size
  typedef struct packed {
    logic [8:0]  n;        // clamped row size
    logic [6:0]  half_d;   // (n - 1) / 2
    logic [31:0] step_q;   // physical_size / (n - 1)
    logic [7:0]  step_r;   // physical_size % (n - 1)
    logic [31:0] recip_d;  // ceil(2^32 / (n - 1)), mod 2^32
    logic [31:0] recip_n;  // ceil(2^32 / n)
    logic        busy;     // constants being recomputed
  } setup_t;

  typedef struct packed {
    logic [23:0] blend;
    logic [23:0] texture;
    logic        last;
  } side_t;

endpackage

@@ rtl/hgvb_setup.sv @@
// Derives grid step and reciprocal constants with a shared bit-serial divider.
module hgvb_setup
  import hgvb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        restart,
  input  logic [8:0]  row_size,
  input  logic [31:0] physical_size,
  output setup_t      setup
);

  seq_state_t  state, state_next;
  job_t        job, job_next;
  logic [5:0]  cnt, cnt_next;
  logic [8:0]  rem, rem_next;
  logic [32:0] quo, quo_next;
  logic [8:0]  divisor, divisor_next;
  logic [31:0] step_q, step_q_next;
  logic [7:0]  step_r, step_r_next;
  logic [31:0] recip_d, recip_d_next;
  logic [31:0] recip_n, recip_n_next;

  logic [8:0]  n;
  logic [7:0]  d;
  logic [9:0]  shifted;
  logic [9:0]  diff;
  logic        take;

  // Clamp row size into 2..MAX_ROW
  always_comb begin
    if (row_size < 9'd2) begin
      n = 9'd2;
    end else if (row_size > 9'(MAX_ROW)) begin
      n = 9'(MAX_ROW);
    end else begin
      n = row_size;
    end
  end

  assign d = 8'(n - 9'd1);

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_LOAD;
      job   <= JOB_STEP;
      cnt   <= '0;
    end else begin
      state <= state_next;
      job   <= job_next;
      cnt   <= cnt_next;
    end
  end

  // Divider datapath and results
  always_ff @(posedge clk) begin
    rem     <= rem_next;
    quo     <= quo_next;
    divisor <= divisor_next;
    step_q  <= step_q_next;
    step_r  <= step_r_next;
    recip_d <= recip_d_next;
    recip_n <= recip_n_next;
  end

  // Restoring division, one quotient bit a cycle
  always_comb begin
    state_next   = state;
    job_next     = job;
    cnt_next     = cnt;
    rem_next     = rem;
    quo_next     = quo;
    divisor_next = divisor;
    step_q_next  = step_q;
    step_r_next  = step_r;
    recip_d_next = recip_d;
    recip_n_next = recip_n;

    shifted = {rem, quo[32]};
    take    = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};

    case (state)
      SEQ_LOAD: begin
        divisor_next = (job == JOB_RECIP_N) ? n : {1'b0, d};
        // ceil(2^32 / v) taken as floor((2^32 + v - 1) / v)
        if (job == JOB_STEP) begin
          quo_next = {1'b0, physical_size};
        end else begin
          quo_next = 33'h1_0000_0000 + 33'(divisor_next) - 33'd1;
        end
        rem_next   = '0;
        cnt_next   = 6'(DIV_STEPS - 1);
        state_next = SEQ_DIV;
      end
      SEQ_DIV: begin
        rem_next = take ? diff[8:0] : shifted[8:0];
        quo_next = {quo[31:0], take};
        cnt_next = cnt - 6'd1;
        if (cnt == '0) begin
          case (job)
            JOB_STEP: begin
              step_q_next = quo_next[31:0];
              step_r_next = rem_next[7:0];
              job_next    = JOB_RECIP_D;
              state_next  = SEQ_LOAD;
            end
            JOB_RECIP_D: begin
              recip_d_next = quo_next[31:0];
              job_next     = JOB_RECIP_N;
              state_next   = SEQ_LOAD;
            end
            JOB_RECIP_N: begin
              recip_n_next = quo_next[31:0];
              state_next   = SEQ_DONE;
            end
            default: begin
              job_next   = JOB_STEP;
              state_next = SEQ_LOAD;
            end
          endcase
        end
      end
      SEQ_DONE: begin
        state_next = SEQ_DONE;
      end
      default: begin
        state_next = SEQ_LOAD;
        job_next   = JOB_STEP;
      end
    endcase

    // new grid size: start over
    if (restart) begin
      state_next = SEQ_LOAD;
      job_next   = JOB_STEP;
    end
  end

  assign setup.n       = n;
  assign setup.half_d  = d[7:1];
  assign setup.step_q  = step_q;
  assign setup.step_r  = step_r;
  assign setup.recip_d = recip_d;
  assign setup.recip_n = recip_n;
  assign setup.busy    = (state != SEQ_DONE);

endmodule

@@ rtl/heightmap_grid_vertex_builder.sv @@
// Top level: configuration registers and the vertex datapath pipeline.
//
// One word in on the input channel (grid index, height, alphas, slots, last flag) gives
// one word out on the output channel (transformed position, blend word, texture word,
// last flag), in order. Both channels use valid/ready.
// The datapath is a 9-stage pipeline (input register, row/column divide by reciprocal,
// grid step products, rounding, saturation, basis products, two adder levels, output
// register). Throughput: one word per cycle while out_ready is high and the constants
// are not being rebuilt. Each stage holds while the stage after it is full and stalled,
// so a stalled receiver fills the empty stages first and then drops in_ready; nothing
// is lost or repeated.
// The grid constants (step = size / (row - 1) as quotient and remainder, and the
// reciprocals of row and row - 1) come from a bit-serial divider in 3 passes. It runs after
// reset and after every write of row_size or physical_size; in_ready stays low meanwhile.
// Other registers take effect at once.
// Configuration writes are taken in any cycle with cfg_write high; reset restores the
// identity transform, row size 2, size 1.0 and an all-unmapped texture map.
module heightmap_grid_vertex_builder
  import hgvb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_write,
  input  logic [REG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [15:0]            vertex_index,
  input  logic signed [31:0]     height,
  input  logic [7:0]             alpha_a,
  input  logic [7:0]             alpha_b,
  input  logic [7:0]             alpha_c,
  input  logic [2:0]             slot_a,
  input  logic [2:0]             slot_b,
  input  logic [2:0]             slot_c,
  input  logic                   last_in,
  // output words
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     pos_x,
  output logic signed [31:0]     pos_y,
  output logic signed [31:0]     pos_z,
  output logic [23:0]            blend_word,
  output logic [23:0]            texture_word,
  output logic                   last_out
);

  // Configuration registers
  logic [8:0]         row_size;
  logic [31:0]        physical_size;
  logic [62:0]        basis_x_row;
  logic [62:0]        basis_y_row;
  logic [62:0]        basis_z_row;
  logic [63:0]        offset_xy;
  logic signed [31:0] offset_z;
  logic [63:0]        texture_map;

  setup_t setup;
  logic   restart;

  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] rdy;
  logic                   take;
  side_t                  side_in;
  side_t                  side_p [PIPE_STAGES];

  // Stage payloads
  logic [15:0]        idx_s0, idx_s1;
  logic signed [31:0] h_s0, h_s1, h_s2, h_s3, h_s4, h_s5;
  logic [47:0]        prod_s1;
  logic [15:0]        row_s2;
  logic [7:0]         col_s2;
  logic [47:0]        rq_s3, rq_s4;
  logic [39:0]        cq_s3, cq_s4;
  logic [23:0]        ru_s3;
  logic [15:0]        cu_s3;
  logic [23:0]        rf_s4;
  logic [15:0]        cf_s4;
  logic signed [31:0] lx_s5, lz_s5;
  logic signed [52:0] px_s6 [3];
  logic signed [52:0] py_s6 [3];
  logic signed [52:0] pz_s6 [3];
  logic signed [55:0] a_s7 [3];
  logic signed [55:0] b_s7 [3];
  logic signed [31:0] pos_s8 [3];

  // Combinational helpers
  logic [55:0]        rf_prod;
  logic [47:0]        cf_prod;
  logic [40:0]        lx_full;
  logic [47:0]        lz_full;
  logic signed [31:0] off [3];
  logic signed [49:0] off_ext [3];
  logic signed [55:0] sum [3];

  function automatic logic [7:0] pool_id(input logic [2:0] slot, input logic [63:0] map);
    logic [7:0] id;
    if ({1'b0, slot} >= 4'(TEXTURE_SLOTS)) begin
      id = POOL_UNMAPPED;
    end else begin
      id = map[8*slot +: 8];
    end
    return id;
  endfunction

  function automatic logic signed [31:0] sat_q(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_size      <= 9'd2;
      physical_size <= 32'h0001_0000;
      basis_x_row   <= 63'(64'd262144);
      basis_y_row   <= 63'(64'd549755813888);
      basis_z_row   <= 63'(64'd1152921504606846976);
      offset_xy     <= '0;
      offset_z      <= '0;
      texture_map   <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_SIZE:      row_size      <= cfg_data[8:0];
        REG_PHYSICAL_SIZE: physical_size <= cfg_data[31:0];
        REG_BASIS_X_ROW:   basis_x_row   <= cfg_data[62:0];
        REG_BASIS_Y_ROW:   basis_y_row   <= cfg_data[62:0];
        REG_BASIS_Z_ROW:   basis_z_row   <= cfg_data[62:0];
        REG_OFFSET_XY:     offset_xy     <= cfg_data;
        REG_OFFSET_Z:      offset_z      <= signed'(cfg_data[31:0]);
        REG_TEXTURE_MAP:   texture_map   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign restart = cfg_write && (cfg_index == REG_ROW_SIZE || cfg_index == REG_PHYSICAL_SIZE);

  hgvb_setup u_setup (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .row_size      (row_size),
    .physical_size (physical_size),
    .setup         (setup)
  );

  // Per-stage flow control: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || out_ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[0] && !setup.busy;
  assign take      = in_valid && in_ready;
  assign out_valid = vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= take;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Blend and texture words ride alongside the arithmetic
  assign side_in.blend   = {alpha_a, alpha_b, alpha_c};
  assign side_in.texture = {pool_id(slot_a, texture_map), pool_id(slot_b, texture_map),
                            pool_id(slot_c, texture_map)};
  assign side_in.last    = last_in;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side_p[0] <= side_in;
    end
    for (int k = 1; k < PIPE_STAGES; k++) begin
      if (rdy[k]) begin
        side_p[k] <= side_p[k-1];
      end
    end
  end

  // Stage 0: input register
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      idx_s0 <= vertex_index;
      h_s0   <= height;
    end
  end

  // Stage 1: index times reciprocal of row size
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      prod_s1 <= 48'(idx_s0) * 48'(setup.recip_n);
      idx_s1  <= idx_s0;
      h_s1    <= h_s0;
    end
  end

  // Stage 2: row is the high half, column the remainder
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      row_s2 <= prod_s1[47:32];
      col_s2 <= 8'(idx_s1 - 16'(25'(prod_s1[47:32]) * 25'(setup.n)));
      h_s2   <= h_s1;
    end
  end

  // Stage 3: whole steps and rounding numerators of the leftover fraction
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      rq_s3 <= 48'(row_s2) * 48'(setup.step_q);
      cq_s3 <= 40'(col_s2) * 40'(setup.step_q);
      ru_s3 <= 24'(row_s2) * 24'(setup.step_r) + 24'(setup.half_d);
      cu_s3 <= 16'(col_s2) * 16'(setup.step_r) + 16'(setup.half_d);
      h_s3  <= h_s2;
    end
  end

  // Stage 4: leftover fraction divided by (row size - 1), rounded half up
  assign rf_prod = 56'(ru_s3) * 56'(setup.recip_d);
  assign cf_prod = 48'(cu_s3) * 48'(setup.recip_d);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      rf_s4 <= rf_prod[55:32];
      cf_s4 <= cf_prod[47:32];
      rq_s4 <= rq_s3;
      cq_s4 <= cq_s3;
      h_s4  <= h_s3;
    end
  end

  // Stage 5: local x and z, saturated; z points away from the rows
  assign lx_full = 41'(cq_s4) + 41'(cf_s4);
  assign lz_full = rq_s4 + 48'(rf_s4);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      if (lx_full > 41'h0_7FFF_FFFF) begin
        lx_s5 <= 32'sh7FFF_FFFF;
      end else begin
        lx_s5 <= signed'(lx_full[31:0]);
      end
      if (lz_full >= 48'h0000_8000_0000) begin
        lz_s5 <= 32'sh8000_0000;
      end else begin
        lz_s5 <= -signed'(lz_full[31:0]);
      end
      h_s5 <= h_s4;
    end
  end

  // Stage 6: basis products, Q16.16 times Q2.18
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int k = 0; k < 3; k++) begin
        px_s6[k] <= 53'(lx_s5) * 53'(signed'(basis_x_row[21*k +: 21]));
        py_s6[k] <= 53'(h_s5)  * 53'(signed'(basis_y_row[21*k +: 21]));
        pz_s6[k] <= 53'(lz_s5) * 53'(signed'(basis_z_row[21*k +: 21]));
      end
    end
  end

  // Stage 7: first adder level; offset at Q.34 with the rounding half below it
  assign off[0] = signed'(offset_xy[31:0]);
  assign off[1] = signed'(offset_xy[63:32]);
  assign off[2] = offset_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      off_ext[k] = signed'({off[k], ROUND_HALF});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      for (int k = 0; k < 3; k++) begin
        a_s7[k] <= 56'(px_s6[k]) + 56'(py_s6[k]);
        b_s7[k] <= 56'(pz_s6[k]) + 56'(off_ext[k]);
      end
    end
  end

  // Stage 8: final sum, back to Q16.16 (floor), saturate; output register
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = a_s7[k] + b_s7[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      for (int k = 0; k < 3; k++) begin
        pos_s8[k] <= sat_q(sum[k][55:18]);
      end
    end
  end

  assign pos_x        = pos_s8[0];
  assign pos_y        = pos_s8[1];
  assign pos_z        = pos_s8[2];
  assign blend_word   = side_p[PIPE_STAGES-1].blend;
  assign texture_word = side_p[PIPE_STAGES-1].texture;
  assign last_out     = side_p[PIPE_STAGES-1].last;

  // A new grid size blocks input while the constants are rebuilt
  a_restart_blocks: assert property (@(posedge clk) disable iff (rst)
    restart |=> !in_ready)
    else $error("input accepted right after a grid size write");

  // Column from the reciprocal divide stays below the row size
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> ({1'b0, col_s2} < setup.n))
    else $error("column out of range");

  // Local z is never positive
  a_lz_sign: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (lz_s5[31] || lz_s5 == 32'sd0))
    else $error("local z positive");

endmodule

@@ tb/sv/tb_heightmap_grid_vertex_builder.sv @@
// Self-checking testbench for the heightmap grid vertex builder.
module tb_heightmap_grid_vertex_builder;
  import hgvb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RUN_PHASES      = 7;
  localparam int     WORDS_PER_PHASE = 100;
  localparam int     CALM_PHASE      = 3;
  localparam int     SQUEEZE_CYCLES  = 60;
  localparam int     STALL_LIMIT     = 4000;
  localparam int     MAX_REPORTS     = 10;
  localparam longint Q_HIGH          = 64'sh7FFFFFFF;
  localparam longint Q_LOW           = -Q_HIGH - 1;

  typedef struct packed {
    logic [15:0]        index;
    logic signed [31:0] height;
    logic [7:0]         alpha_a;
    logic [7:0]         alpha_b;
    logic [7:0]         alpha_c;
    logic [2:0]         slot_a;
    logic [2:0]         slot_b;
    logic [2:0]         slot_c;
    logic               last;
  } vertex_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [23:0] blend;
    logic [23:0] texture;
    logic        last;
  } vertex_out_t;

  typedef struct packed {
    logic [8:0]  row_size;
    logic [31:0] side;
    logic [62:0] basis_x;
    logic [62:0] basis_y;
    logic [62:0] basis_z;
    logic [63:0] offset_xy;
    logic [31:0] offset_z;
    logic [63:0] texture_map;
  } grid_cfg_t;

  typedef enum logic {PLAN_WRITE, PLAN_VERTEX} plan_kind_e;

  typedef struct {
    plan_kind_e             kind;
    logic [REG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  value;
    vertex_t                vertex;
    bit                     known;
    vertex_out_t            want;
  } plan_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [REG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [15:0]            vertex_index;
  logic signed [31:0]     height;
  logic [7:0]             alpha_a;
  logic [7:0]             alpha_b;
  logic [7:0]             alpha_c;
  logic [2:0]             slot_a;
  logic [2:0]             slot_b;
  logic [2:0]             slot_c;
  logic                   last_in;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [31:0]     pos_x;
  logic signed [31:0]     pos_y;
  logic signed [31:0]     pos_z;
  logic [23:0]            blend_word;
  logic [23:0]            texture_word;
  logic                   last_out;

  // Register copy used by the predictor
  logic [8:0]  cur_row_size;
  logic [31:0] cur_side;
  logic [62:0] cur_basis_x;
  logic [62:0] cur_basis_y;
  logic [62:0] cur_basis_z;
  logic [63:0] cur_offset_xy;
  logic [31:0] cur_offset_z;
  logic [63:0] cur_texture_map;

  vertex_out_t vertices_due[$];
  plan_row_t   plan[$];
  int          mismatches  = 0;
  int          stall_count = 0;
  bit          calm        = 1'b0;
  bit          squeeze_req = 1'b0;

  heightmap_grid_vertex_builder u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vertex_index (vertex_index),
    .height       (height),
    .alpha_a      (alpha_a),
    .alpha_b      (alpha_b),
    .alpha_c      (alpha_c),
    .slot_a       (slot_a),
    .slot_b       (slot_b),
    .slot_c       (slot_c),
    .last_in      (last_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .blend_word   (blend_word),
    .texture_word (texture_word),
    .last_out     (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic longint clamp_q(input longint v);
    if (v < Q_LOW) return Q_LOW;
    if (v > Q_HIGH) return Q_HIGH;
    return v;
  endfunction

  function automatic int unsigned grid_rows();
    if (cur_row_size < 2) return 2;
    if (cur_row_size > MAX_ROW) return MAX_ROW;
    return cur_row_size;
  endfunction

  // Q2.18 coefficient k of a packed basis row
  function automatic longint coef_of(input logic [62:0] basis, input int k);
    logic signed [20:0] c;
    c = basis[21*k +: 21];
    return longint'(c);
  endfunction

  function automatic logic [7:0] pool_of(input logic [2:0] slot);
    if (slot >= TEXTURE_SLOTS) return POOL_UNMAPPED;
    return cur_texture_map[8*slot +: 8];
  endfunction

  function automatic vertex_out_t transform_vertex(input vertex_t v);
    longint unsigned n, d, row, col, side;
    longint          lx, ly, lz, acc;
    longint          offs[3];
    longint          pos[3];
    int              k;
    vertex_out_t     r;
    n    = grid_rows();
    d    = n - 1;
    row  = v.index / n;
    col  = v.index % n;
    side = cur_side;
    // grid point rounded to nearest, ties away from zero, then saturated
    lx = clamp_q(longint'((2 * col * side + d) / (2 * d)));
    lz = clamp_q(-longint'((2 * row * side + d) / (2 * d)));
    ly = longint'($signed(v.height));
    offs[0] = longint'($signed(cur_offset_xy[31:0]));
    offs[1] = longint'($signed(cur_offset_xy[63:32]));
    offs[2] = longint'($signed(cur_offset_z));
    // exact sum at Q.34, rounded half up to Q16.16
    for (k = 0; k < 3; k++) begin
      acc = lx * coef_of(cur_basis_x, k) + ly * coef_of(cur_basis_y, k)
          + lz * coef_of(cur_basis_z, k) + offs[k] * 262144;
      pos[k] = clamp_q((acc + 131072) >>> 18);
    end
    r.pos_x   = pos[0][31:0];
    r.pos_y   = pos[1][31:0];
    r.pos_z   = pos[2][31:0];
    r.blend   = {v.alpha_a, v.alpha_b, v.alpha_c};
    r.texture = {pool_of(v.slot_a), pool_of(v.slot_b), pool_of(v.slot_c)};
    r.last    = v.last;
    return r;
  endfunction

  // ---------------------------------------------------------------- directed plan

  function automatic vertex_t vtx(input logic [15:0] idx, input logic [31:0] h,
                                  input logic [7:0] aa, input logic [7:0] ab,
                                  input logic [7:0] ac, input logic [2:0] sa,
                                  input logic [2:0] sb, input logic [2:0] sc,
                                  input logic lst);
    vertex_t v;
    v.index   = idx;
    v.height  = h;
    v.alpha_a = aa;
    v.alpha_b = ab;
    v.alpha_c = ac;
    v.slot_a  = sa;
    v.slot_b  = sb;
    v.slot_c  = sc;
    v.last    = lst;
    return v;
  endfunction

  function automatic vertex_out_t res(input logic [31:0] px, input logic [31:0] py,
                                      input logic [31:0] pz, input logic [23:0] bw,
                                      input logic [23:0] tw, input logic lst);
    vertex_out_t r;
    r.pos_x   = px;
    r.pos_y   = py;
    r.pos_z   = pz;
    r.blend   = bw;
    r.texture = tw;
    r.last    = lst;
    return r;
  endfunction

  function automatic void plan_write(input logic [REG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] value);
    plan_row_t p;
    p.kind      = PLAN_WRITE;
    p.reg_index = idx;
    p.value     = value;
    p.vertex    = '0;
    p.known     = 1'b0;
    p.want      = '0;
    plan.push_back(p);
  endfunction

  function automatic void plan_vertex(input vertex_t v, input bit known,
                                      input vertex_out_t want);
    plan_row_t p;
    p.kind      = PLAN_VERTEX;
    p.reg_index = REG_ROW_SIZE;
    p.value     = '0;
    p.vertex    = v;
    p.known     = known;
    p.want      = want;
    plan.push_back(p);
  endfunction

  function automatic void build_plan();
    // identity transform after reset: x = column, z = -row, in whole units
    plan_vertex(vtx(16'd0, 32'h0, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0, 3'd0, 1'b0), 1'b1,
                res(32'h0, 32'h0, 32'h0, 24'h000000, 24'hFFFFFF, 1'b0));
    plan_vertex(vtx(16'd1, 32'h7FFFFFFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 3'd7, 3'd7, 1'b1), 1'b1,
                res(32'h00010000, 32'h7FFFFFFF, 32'h0, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
    plan_vertex(vtx(16'd2, 32'h80000000, 8'h12, 8'h34, 8'h56, 3'd1, 3'd2, 3'd3, 1'b0), 1'b1,
                res(32'h0, 32'h80000000, 32'hFFFF0000, 24'h123456, 24'hFFFFFF, 1'b0));
    plan_vertex(vtx(16'd3, 32'hFFFFFFFF, 8'hA5, 8'h5A, 8'hC3, 3'd4, 3'd5, 3'd6, 1'b1), 1'b1,
                res(32'h00010000, 32'hFFFFFFFF, 32'hFFFF0000, 24'hA55AC3, 24'hFFFFFF, 1'b1));
    // index far beyond the grid: the row is not bounded
    plan_vertex(vtx(16'hFFFF, 32'h00010000, 8'h01, 8'h80, 8'h7F, 3'd7, 3'd0, 3'd7, 1'b0),
                1'b1, res(32'h00010000, 32'h00010000, 32'h80010000, 24'h01807F, 24'hFFFFFF,
                          1'b0));
    plan_vertex(vtx(16'hFFFE, 32'h80000001, 8'h80, 8'h01, 8'hFE, 3'd0, 3'd7, 3'd0, 1'b1),
                1'b1, res(32'h0, 32'h80000001, 32'h80010000, 24'h8001FE, 24'hFFFFFF, 1'b1));
    // slot k maps to pool id (k+1)*0x11
    plan_write(REG_TEXTURE_MAP, 64'h8877665544332211);
    plan_vertex(vtx(16'd0, 32'h0, 8'h00, 8'h00, 8'h00, 3'd0, 3'd3, 3'd7, 1'b0), 1'b1,
                res(32'h0, 32'h0, 32'h0, 24'h000000, 24'h114488, 1'b0));
    plan_vertex(vtx(16'd1, 32'h5, 8'h0F, 8'hF0, 8'h3C, 3'd7, 3'd6, 3'd5, 1'b1), 1'b1,
                res(32'h00010000, 32'h5, 32'h0, 24'h0FF03C, 24'h887766, 1'b1));
    // largest side: local x and z saturate before the transform
    plan_write(REG_PHYSICAL_SIZE, 64'hFFFFFFFF);
    plan_vertex(vtx(16'd3, 32'h0, 8'h00, 8'h00, 8'h00, 3'd1, 3'd2, 3'd4, 1'b0), 1'b1,
                res(32'h7FFFFFFF, 32'h0, 32'h80000000, 24'h000000, 24'h223355, 1'b0));
    // row size below the range is taken as 2
    plan_write(REG_ROW_SIZE, 64'd0);
    plan_vertex(vtx(16'd2, 32'h0, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0, 3'd0, 1'b1), 1'b1,
                res(32'h0, 32'h0, 32'h80000000, 24'h000000, 24'h111111, 1'b1));
    // row size above the range is taken as the largest row
    plan_write(REG_ROW_SIZE, 64'h1FF);
    plan_write(REG_PHYSICAL_SIZE, 64'd1);
    plan_vertex(vtx(16'd255, 32'h00001234, 8'h11, 8'h22, 8'h33, 3'd0, 3'd1, 3'd2, 1'b0),
                1'b0, '0);
    plan_vertex(vtx(16'd128, 32'hFFFFFFFE, 8'h44, 8'h55, 8'h66, 3'd3, 3'd4, 3'd5, 1'b0),
                1'b0, '0);
    plan_vertex(vtx(16'd127, 32'h00000001, 8'h77, 8'h88, 8'h99, 3'd6, 3'd7, 3'd0, 1'b0),
                1'b0, '0);
    plan_vertex(vtx(16'hFFFF, 32'h80000000, 8'hAA, 8'hBB, 8'hCC, 3'd1, 3'd3, 3'd5, 1'b1),
                1'b0, '0);
    plan_write(REG_ROW_SIZE, 64'd1);
    plan_write(REG_PHYSICAL_SIZE, 64'd3);
    plan_vertex(vtx(16'd1, 32'h00000100, 8'h01, 8'h02, 8'h03, 3'd2, 3'd4, 3'd6, 1'b0), 1'b1,
                res(32'h3, 32'h00000100, 32'h0, 24'h010203, 24'h335577, 1'b0));
    // half a unit of the grid step rounds away from zero
    plan_write(REG_ROW_SIZE, 64'd3);
    plan_write(REG_PHYSICAL_SIZE, 64'd1);
    plan_vertex(vtx(16'd1, 32'h0, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0, 3'd0, 1'b0), 1'b1,
                res(32'h1, 32'h0, 32'h0, 24'h000000, 24'h111111, 1'b0));
    plan_vertex(vtx(16'd4, 32'h7, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0, 3'd0, 1'b1), 1'b1,
                res(32'h1, 32'h7, 32'hFFFFFFFF, 24'h000000, 24'h111111, 1'b1));
    plan_vertex(vtx(16'd8, 32'hFFFFFFF0, 8'h5A, 8'hA5, 8'h3C, 3'd7, 3'd1, 3'd6, 1'b0),
                1'b0, '0);
    // extreme coefficients and offsets, and a product tie at half an LSB
    plan_write(REG_PHYSICAL_SIZE, 64'hFFFFFFFF);
    plan_write(REG_BASIS_X_ROW, {1'b0, 21'h100000, 21'h100000, 21'h100000});
    plan_write(REG_BASIS_Y_ROW, {1'b0, 21'h020000, 21'h1E0000, 21'h020000});
    plan_write(REG_BASIS_Z_ROW, {1'b0, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
    plan_write(REG_OFFSET_XY, 64'h7FFFFFFF80000000);
    plan_write(REG_OFFSET_Z, 64'h000000007FFFFFFF);
    plan_vertex(vtx(16'd0, 32'h1, 8'h00, 8'hFF, 8'h00, 3'd0, 3'd7, 3'd0, 1'b0), 1'b0, '0);
    plan_vertex(vtx(16'd0, 32'hFFFFFFFF, 8'hFF, 8'h00, 8'hFF, 3'd7, 3'd0, 3'd7, 1'b0),
                1'b0, '0);
    plan_vertex(vtx(16'd2, 32'h7FFFFFFF, 8'h12, 8'h34, 8'h56, 3'd5, 3'd6, 3'd7, 1'b0),
                1'b0, '0);
    plan_vertex(vtx(16'hFFFF, 32'h80000000, 8'h65, 8'h43, 8'h21, 3'd2, 3'd1, 3'd0, 1'b1),
                1'b0, '0);
  endfunction

  // ---------------------------------------------------------------- random stimulus

  function automatic logic [62:0] pick_basis(input bit tame);
    logic [62:0] r;
    int          k;
    for (k = 0; k < 3; k++) begin
      if (tame) r[21*k +: 21] = 21'($urandom_range(524288) - 262144);
      else r[21*k +: 21] = 21'($urandom);
    end
    return r;
  endfunction

  function automatic grid_cfg_t pick_grid(input int phase);
    grid_cfg_t g;
    bit        tame;
    tame = ($urandom_range(1) == 0);
    case ($urandom_range(9))
      0:       g.row_size = 9'($urandom_range(1));
      1:       g.row_size = 9'($urandom_range(511, 257));
      default: g.row_size = 9'($urandom_range(MAX_ROW, 2));
    endcase
    case ($urandom_range(2))
      0:       g.side = $urandom;
      1:       g.side = $urandom_range(1 << 22);
      default: g.side = 32'((g.row_size % 256 + 1) * 65536 * $urandom_range(4, 1));
    endcase
    g.basis_x     = pick_basis(tame);
    g.basis_y     = pick_basis(tame);
    g.basis_z     = pick_basis(tame);
    g.offset_xy   = {$urandom, $urandom};
    g.offset_z    = $urandom;
    g.texture_map = {$urandom, $urandom};
    if (tame) begin
      g.offset_xy = {32'($signed(g.offset_xy[63:32]) >>> 8),
                     32'($signed(g.offset_xy[31:0]) >>> 8)};
      g.offset_z  = 32'($signed(g.offset_z) >>> 8);
    end
    case (phase)
      0: begin
        // all registers at their minima
        g = '0;
        g.row_size = 9'd2;
      end
      1: begin
        g.row_size    = 9'(MAX_ROW);
        g.side        = '1;
        g.basis_x     = '1;
        g.basis_y     = '1;
        g.basis_z     = '1;
        g.offset_xy   = '1;
        g.offset_z    = 32'h80000000;
        g.texture_map = '1;
      end
      2: begin
        // identity transform on a random grid
        g.basis_x   = 63'(1) << 18;
        g.basis_y   = 63'(1) << 39;
        g.basis_z   = 63'(1) << 60;
        g.offset_xy = '0;
        g.offset_z  = '0;
      end
      default: ;
    endcase
    return g;
  endfunction

  function automatic vertex_t random_vertex();
    vertex_t     v;
    int unsigned n;
    n = grid_rows();
    v = vtx(16'($urandom), $urandom, 8'($urandom), 8'($urandom), 8'($urandom),
            3'($urandom), 3'($urandom), 3'($urandom), ($urandom_range(7) == 0));
    // mostly points on the grid, the rest anywhere in the index range
    if ($urandom_range(3) != 0) v.index = 16'($urandom_range(n * n - 1));
    if ($urandom_range(1) == 0) v.height = $signed(v.height) >>> 8;
    return v;
  endfunction

  function automatic int idle_run();
    int n;
    n = 0;
    if (calm) return 0;
    while ($urandom_range(99) < 33) n++;
    return n;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Entered and left at a falling edge; cfg_write is left high
  task automatic write_reg(input logic [REG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_ROW_SIZE:      cur_row_size    = value[8:0];
      REG_PHYSICAL_SIZE: cur_side        = value[31:0];
      REG_BASIS_X_ROW:   cur_basis_x     = value[62:0];
      REG_BASIS_Y_ROW:   cur_basis_y     = value[62:0];
      REG_BASIS_Z_ROW:   cur_basis_z     = value[62:0];
      REG_OFFSET_XY:     cur_offset_xy   = value;
      REG_OFFSET_Z:      cur_offset_z    = value[31:0];
      REG_TEXTURE_MAP:   cur_texture_map = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_write <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  // Drain the pipeline before touching the registers
  task automatic quiesce();
    in_valid <= 1'b0;
    while (vertices_due.size() != 0) @(posedge clk);
    repeat (PIPE_STAGES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_grid(input grid_cfg_t g);
    write_reg(REG_ROW_SIZE, 64'(g.row_size));
    write_reg(REG_PHYSICAL_SIZE, 64'(g.side));
    write_reg(REG_BASIS_X_ROW, 64'(g.basis_x));
    write_reg(REG_BASIS_Y_ROW, 64'(g.basis_y));
    write_reg(REG_BASIS_Z_ROW, 64'(g.basis_z));
    write_reg(REG_OFFSET_XY, g.offset_xy);
    write_reg(REG_OFFSET_Z, 64'(g.offset_z));
    write_reg(REG_TEXTURE_MAP, g.texture_map);
    end_writes();
  endtask

  // Offer one input word; valid stays high until the word is taken
  task automatic offer_vertex(input vertex_t v, input bit known, input vertex_out_t want);
    int gap;
    gap = idle_run();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    vertex_index <= v.index;
    height       <= v.height;
    alpha_a      <= v.alpha_a;
    alpha_b      <= v.alpha_b;
    alpha_c      <= v.alpha_c;
    slot_a       <= v.slot_a;
    slot_b       <= v.slot_b;
    slot_c       <= v.slot_c;
    last_in      <= v.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    vertices_due.push_back(known ? want : transform_vertex(v));
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    plan_row_t p;
    bit        writing;
    int        ph;
    int        i;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = REG_ROW_SIZE;
    cfg_data        = '0;
    in_valid        = 1'b0;
    vertex_index    = '0;
    height          = '0;
    alpha_a         = '0;
    alpha_b         = '0;
    alpha_c         = '0;
    slot_a          = '0;
    slot_b          = '0;
    slot_c          = '0;
    last_in         = 1'b0;
    cur_row_size    = 9'd2;
    cur_side        = 32'h00010000;
    cur_basis_x     = 63'(1) << 18;
    cur_basis_y     = 63'(1) << 39;
    cur_basis_z     = 63'(1) << 60;
    cur_offset_xy   = '0;
    cur_offset_z    = '0;
    cur_texture_map = '1;
    writing         = 1'b0;
    build_plan();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[r]) begin
      p = plan[r];
      if (p.kind == PLAN_WRITE) begin
        if (!writing) quiesce();
        writing = 1'b1;
        write_reg(p.reg_index, p.value);
      end else begin
        if (writing) end_writes();
        writing = 1'b0;
        offer_vertex(p.vertex, p.known, p.want);
      end
    end

    // random phases, each under its own register setting
    for (ph = 0; ph < RUN_PHASES; ph++) begin
      quiesce();
      apply_grid(pick_grid(ph));
      calm = (ph == CALM_PHASE);
      for (i = 0; i < WORDS_PER_PHASE; i++) begin
        if (calm && i == 20) squeeze_req = 1'b1;
        offer_vertex(random_vertex(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    while (vertices_due.size() != 0) @(posedge clk);
    repeat (2 * PIPE_STAGES) @(posedge clk);
    if (mismatches == 0 && vertices_due.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // Random back-pressure, plus one long hold-off so the pipeline fills and stalls
  initial begin : receiver
    int held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_ready <= 1'b0;
        for (held = 0; held < SQUEEZE_CYCLES; held++) @(negedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    vertex_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (vertices_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: output word with none expected: x %h y %h z %h", $time,
                   pos_x, pos_y, pos_z);
      end else begin
        want = vertices_due.pop_front();
        check_field("pos_x", want.pos_x, pos_x);
        check_field("pos_y", want.pos_y, pos_y);
        check_field("pos_z", want.pos_z, pos_z);
        check_field("blend_word", 32'(want.blend), 32'(blend_word));
        check_field("texture_word", 32'(want.texture), 32'(texture_word));
        check_field("last_out", 32'(want.last), 32'(last_out));
      end
    end
  end

  // Watchdog: too long without any word moving on either channel
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

endmodule
